FILE: hw/rtl/rhtt_pkg.sv
package rhtt_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int COORD_BITS_DEF = 12;

    localparam int CMD_W    = 3;
    localparam int PCOORD_W = 12;
    localparam int SLOT_W   = 4;
    localparam int HIT_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int EXT_W    = 17;

    localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_LAST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE_INDEX = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE_POINT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOOKUP      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_COUNT_M1,
        PTR_SLOT,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTR_INC,
        RD_PTR_DEC,
        RD_PTR_INC2
    } rd_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_UP,
        WR_DOWN
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic                load;
        ptr_op_t             ptr_op;
        rd_op_t              rd_op;
        wr_op_t              wr_op;
        cnt_op_t             cnt_op;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                set_hit;
        logic                out_load;
    } rhtt_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             count_zero;
        logic             count_full;
        logic             slot_oob;
        logic             ptr_zero;
        logic             ptr_last;
        logic             next_last;
        logic             hit;
    } rhtt_stat_t;

endpackage

FILE: hw/rtl/rectangle_hit_test_table_core.sv
// Ordered rectangle table with point hit test.
// Command channel: cmd_valid/cmd_stall carry one command transaction with
// its corners, query point and slot. Response channel: rsp_valid/rsp_stall
// carry found, hit_index, entry_count and status, one per command.
// One command is worked on at a time; cmd_stall is high from the cycle after
// acceptance until the result is loaded into the response register.
// Every step is one access of the single table memory (one read and at most
// one write per cycle), so latency follows the number of entries visited.
// Steps per command: remove last, errors, unused codes and insert into an
// empty table finish straight from decode; insert moves each stored entry
// back one slot, from the last down, then writes the new one at slot 0;
// erase at index moves each entry behind the slot forward one slot; lookup
// scans from slot 0 to the first hit or the last entry; erase at point scans
// as lookup and on a hit erases that slot as erase at index does.
// The next command can be taken in the cycle after the result is loaded.
// Reset empties the table and clears rsp_valid; no clearing pass is needed.
// A stalled response holds its payload; the next command may be accepted and
// worked on meanwhile, and waits at its end until the response is taken.
module rectangle_hit_test_table_core
    import rhtt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [PCOORD_W-1:0] corner_ax,
    input  logic [PCOORD_W-1:0] corner_ay,
    input  logic [PCOORD_W-1:0] corner_bx,
    input  logic [PCOORD_W-1:0] corner_by,
    input  logic [PCOORD_W-1:0] point_x,
    input  logic [PCOORD_W-1:0] point_y,
    input  logic [SLOT_W-1:0]   slot_index,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic                found,
    output logic [HIT_W-1:0]    hit_index,
    output logic [COUNT_W-1:0]  entry_count,
    output logic [STATUS_W-1:0] status
);

    rhtt_ctrl_t ctrl;
    rhtt_stat_t stat;

    rhtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    rhtt_datapath #(
        .DEPTH      (DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .command     (command),
        .corner_ax   (corner_ax),
        .corner_ay   (corner_ay),
        .corner_bx   (corner_bx),
        .corner_by   (corner_by),
        .point_x     (point_x),
        .point_y     (point_y),
        .slot_index  (slot_index),
        .found       (found),
        .hit_index   (hit_index),
        .entry_count (entry_count),
        .status      (status)
    );

endmodule

FILE: hw/rtl/rhtt_datapath.sv
module rhtt_datapath
    import rhtt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rhtt_ctrl_t          ctrl,
    output rhtt_stat_t          stat,
    input  logic [CMD_W-1:0]    command,
    input  logic [PCOORD_W-1:0] corner_ax,
    input  logic [PCOORD_W-1:0] corner_ay,
    input  logic [PCOORD_W-1:0] corner_bx,
    input  logic [PCOORD_W-1:0] corner_by,
    input  logic [PCOORD_W-1:0] point_x,
    input  logic [PCOORD_W-1:0] point_y,
    input  logic [SLOT_W-1:0]   slot_index,
    output logic                found,
    output logic [HIT_W-1:0]    hit_index,
    output logic [COUNT_W-1:0]  entry_count,
    output logic [STATUS_W-1:0] status
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = 4 * COORD_BITS;

    function automatic logic [COORD_BITS-1:0] trim(input logic [PCOORD_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = {{(EXT_W-PCOORD_W){1'b0}}, v};
        return e[COORD_BITS-1:0];
    endfunction

    logic [EW-1:0]         rect_mem [DEPTH];
    logic [EW-1:0]         rd_data_reg;

    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [COORD_BITS-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [COORD_BITS-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [IW-1:0]         ptr_reg, ptr_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         hitpos_reg, hitpos_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  found_out_reg, found_out_next;
    logic [HIT_W-1:0]      hit_out_reg, hit_out_next;
    logic [COUNT_W-1:0]    count_out_reg, count_out_next;
    logic [STATUS_W-1:0]   status_out_reg, status_out_next;

    logic [EXT_W-1:0]      ptr_x, count_x, slot_x, hitpos_x;
    logic [IW-1:0]         rd_addr, wr_addr;
    logic                  wr_en;
    logic [EW-1:0]         wr_data, new_entry;
    logic [COORD_BITS-1:0] xl, xh, yl, yh;

    assign ptr_x    = {{(EXT_W-IW){1'b0}}, ptr_reg};
    assign count_x  = {{(EXT_W-CW){1'b0}}, count_reg};
    assign slot_x   = {{(EXT_W-SLOT_W){1'b0}}, slot_reg};
    assign hitpos_x = {{(EXT_W-IW){1'b0}}, hitpos_reg};

    assign xl = rd_data_reg[COORD_BITS-1:0];
    assign xh = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign yl = rd_data_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign yh = rd_data_reg[4*COORD_BITS-1:3*COORD_BITS];

    assign new_entry = {
        (ay_reg < by_reg) ? by_reg : ay_reg,
        (ay_reg < by_reg) ? ay_reg : by_reg,
        (ax_reg < bx_reg) ? bx_reg : ax_reg,
        (ax_reg < bx_reg) ? ax_reg : bx_reg
    };

    assign stat.cmd        = cmd_reg;
    assign stat.count_zero = (count_x == '0);
    assign stat.count_full = (count_x == EXT_W'(DEPTH));
    assign stat.slot_oob   = (slot_x >= count_x);
    assign stat.ptr_zero   = (ptr_x == '0);
    assign stat.ptr_last   = ((ptr_x + EXT_W'(1)) == count_x);
    assign stat.next_last  = ((ptr_x + EXT_W'(2)) == count_x);
    assign stat.hit        = (px_reg > xl) && (px_reg < xh) && (py_reg > yl) && (py_reg < yh);

    always_comb
    begin
        case (ctrl.rd_op)
            RD_PTR:      rd_addr = ptr_reg;
            RD_PTR_INC:  rd_addr = ptr_reg + IW'(1);
            RD_PTR_DEC:  rd_addr = ptr_reg - IW'(1);
            RD_PTR_INC2: rd_addr = ptr_reg + IW'(2);
            default:     rd_addr = ptr_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data_reg;
        case (ctrl.wr_op)
            WR_NEW:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = new_entry;
            end
            WR_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg + IW'(1);
            end
            WR_DOWN:
            begin
                wr_en   = 1'b1;
            end
            default:
            begin
                wr_en   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rect_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= rect_mem[rd_addr];
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        slot_next       = slot_reg;
        found_next      = found_reg;
        hitpos_next     = hitpos_reg;
        status_next     = status_reg;
        found_out_next  = found_out_reg;
        hit_out_next    = hit_out_reg;
        count_out_next  = count_out_reg;
        status_out_next = status_out_reg;

        if (ctrl.load)
        begin
            cmd_next    = command;
            ax_next     = trim(corner_ax);
            ay_next     = trim(corner_ay);
            bx_next     = trim(corner_bx);
            by_next     = trim(corner_by);
            px_next     = trim(point_x);
            py_next     = trim(point_y);
            slot_next   = slot_index;
            found_next  = 1'b0;
            hitpos_next = '0;
            status_next = ST_OK;
        end
        if (ctrl.set_status)
        begin
            status_next = ctrl.status_code;
        end
        if (ctrl.set_hit)
        begin
            found_next  = 1'b1;
            hitpos_next = ptr_reg;
        end
        if (ctrl.out_load)
        begin
            found_out_next  = found_reg;
            hit_out_next    = hitpos_x[HIT_W-1:0];
            count_out_next  = count_x[COUNT_W-1:0];
            status_out_next = status_reg;
        end

        case (ctrl.ptr_op)
            PTR_COUNT_M1: ptr_next = count_x[IW-1:0] - IW'(1);
            PTR_SLOT:     ptr_next = slot_x[IW-1:0];
            PTR_ZERO:     ptr_next = '0;
            PTR_INC:      ptr_next = ptr_reg + IW'(1);
            PTR_DEC:      ptr_next = ptr_reg - IW'(1);
            default:      ptr_next = ptr_reg;
        endcase

        case (ctrl.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        bx_reg         <= bx_next;
        by_reg         <= by_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        slot_reg       <= slot_next;
        ptr_reg        <= ptr_next;
        found_reg      <= found_next;
        hitpos_reg     <= hitpos_next;
        status_reg     <= status_next;
        found_out_reg  <= found_out_next;
        hit_out_reg    <= hit_out_next;
        count_out_reg  <= count_out_next;
        status_out_reg <= status_out_next;
    end

    assign found       = found_out_reg;
    assign hit_index   = hit_out_reg;
    assign entry_count = count_out_reg;
    assign status      = status_out_reg;

endmodule

FILE: hw/rtl/rhtt_ctrl.sv
module rhtt_ctrl
    import rhtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rhtt_ctrl_t ctrl,
    input  rhtt_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_PRIME,
        S_UP_MOVE,
        S_UP_NEW,
        S_DN_START,
        S_DN_MOVE,
        S_SC_PRIME,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        ctrl.load        = 1'b0;
        ctrl.ptr_op      = PTR_HOLD;
        ctrl.rd_op       = RD_PTR;
        ctrl.wr_op       = WR_NONE;
        ctrl.cnt_op      = CNT_HOLD;
        ctrl.set_status  = 1'b0;
        ctrl.status_code = ST_OK;
        ctrl.set_hit     = 1'b0;
        ctrl.out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                unique case (stat.cmd) inside
                    CMD_INSERT:
                    begin
                        if (stat.count_full)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_FULL;
                        end
                        else if (stat.count_zero)
                        begin
                            ctrl.wr_op  = WR_NEW;
                            ctrl.cnt_op = CNT_INC;
                        end
                        else
                        begin
                            ctrl.ptr_op = PTR_COUNT_M1;
                            state_next  = S_UP_PRIME;
                        end
                    end
                    CMD_REMOVE_LAST:
                    begin
                        if (stat.count_zero)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_RANGE;
                        end
                        else
                        begin
                            ctrl.cnt_op = CNT_DEC;
                        end
                    end
                    CMD_ERASE_INDEX:
                    begin
                        if (stat.slot_oob)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_RANGE;
                        end
                        else
                        begin
                            ctrl.ptr_op = PTR_SLOT;
                            state_next  = S_DN_START;
                        end
                    end
                    CMD_ERASE_POINT, CMD_LOOKUP:
                    begin
                        if (stat.count_zero)
                        begin
                            ctrl.set_status  = 1'b1;
                            ctrl.status_code = ST_RANGE;
                        end
                        else
                        begin
                            ctrl.ptr_op = PTR_ZERO;
                            state_next  = S_SC_PRIME;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_UP_PRIME:
            begin
                ctrl.rd_op = RD_PTR;
                state_next = S_UP_MOVE;
            end
            S_UP_MOVE:
            begin
                ctrl.wr_op = WR_UP;
                ctrl.rd_op = RD_PTR_DEC;
                if (stat.ptr_zero)
                begin
                    state_next = S_UP_NEW;
                end
                else
                begin
                    ctrl.ptr_op = PTR_DEC;
                end
            end
            S_UP_NEW:
            begin
                ctrl.wr_op  = WR_NEW;
                ctrl.cnt_op = CNT_INC;
                state_next  = S_FINISH;
            end
            S_DN_START:
            begin
                if (stat.ptr_last)
                begin
                    ctrl.cnt_op = CNT_DEC;
                    state_next  = S_FINISH;
                end
                else
                begin
                    ctrl.rd_op = RD_PTR_INC;
                    state_next = S_DN_MOVE;
                end
            end
            S_DN_MOVE:
            begin
                ctrl.wr_op = WR_DOWN;
                ctrl.rd_op = RD_PTR_INC2;
                if (stat.next_last)
                begin
                    ctrl.cnt_op = CNT_DEC;
                    state_next  = S_FINISH;
                end
                else
                begin
                    ctrl.ptr_op = PTR_INC;
                end
            end
            S_SC_PRIME:
            begin
                ctrl.rd_op = RD_PTR;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    ctrl.set_hit = 1'b1;
                    if (stat.cmd == CMD_ERASE_POINT)
                    begin
                        state_next = S_DN_START;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (stat.ptr_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.rd_op  = RD_PTR_INC;
                    ctrl.ptr_op = PTR_INC;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ctrl.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rhtt_pkg::*;

    localparam int COORD_MAX = (1 << PCOORD_W) - 1;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 2 * DEPTH_DEF + 20;
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST = 3'd7;

    typedef struct {
        logic [PCOORD_W-1:0] ax;
        logic [PCOORD_W-1:0] ay;
        logic [PCOORD_W-1:0] bx;
        logic [PCOORD_W-1:0] by;
    } box_t;

    typedef struct {
        logic [CMD_W-1:0]    code;
        box_t                box;
        logic [PCOORD_W-1:0] px;
        logic [PCOORD_W-1:0] py;
        logic [SLOT_W-1:0]   slot;
    } hit_cmd_t;

    typedef struct packed {
        logic                found;
        logic [HIT_W-1:0]    hit;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } hit_rsp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    logic [CMD_W-1:0] command;
    logic [PCOORD_W-1:0] corner_ax;
    logic [PCOORD_W-1:0] corner_ay;
    logic [PCOORD_W-1:0] corner_bx;
    logic [PCOORD_W-1:0] corner_by;
    logic [PCOORD_W-1:0] point_x;
    logic [PCOORD_W-1:0] point_y;
    logic [SLOT_W-1:0] slot_index;
    logic rsp_valid;
    logic rsp_stall;
    logic found;
    logic [HIT_W-1:0] hit_index;
    logic [COUNT_W-1:0] entry_count;
    logic [STATUS_W-1:0] status;

    box_t box_list [DEPTH_DEF];
    int box_count = 0;
    hit_rsp_t pending_rsp [$];
    hit_rsp_t rsp_want;
    int fail_count = 0;
    int cycle_count = 0;
    bit no_idle = 1'b1;

    rectangle_hit_test_table_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .corner_ax   (corner_ax),
        .corner_ay   (corner_ay),
        .corner_bx   (corner_bx),
        .corner_by   (corner_by),
        .point_x     (point_x),
        .point_y     (point_y),
        .slot_index  (slot_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .found       (found),
        .hit_index   (hit_index),
        .entry_count (entry_count),
        .status      (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic box_t make_box(input int ax, input int ay, input int bx, input int by);
        box_t b;
        b.ax = ax[PCOORD_W-1:0];
        b.ay = ay[PCOORD_W-1:0];
        b.bx = bx[PCOORD_W-1:0];
        b.by = by[PCOORD_W-1:0];
        return b;
    endfunction

    function automatic bit box_covers(input box_t b, input logic [PCOORD_W-1:0] px,
                                      input logic [PCOORD_W-1:0] py);
        logic [PCOORD_W-1:0] xl, xh, yl, yh;
        xl = (b.ax < b.bx) ? b.ax : b.bx;
        xh = (b.ax < b.bx) ? b.bx : b.ax;
        yl = (b.ay < b.by) ? b.ay : b.by;
        yh = (b.ay < b.by) ? b.by : b.ay;
        return px > xl && px < xh && py > yl && py < yh;
    endfunction

    function automatic int first_box_hit(input logic [PCOORD_W-1:0] px,
                                         input logic [PCOORD_W-1:0] py);
        for (int i = 0; i < box_count; i++)
        begin
            if (box_covers(box_list[i], px, py))
                return i;
        end
        return -1;
    endfunction

    function automatic void drop_box(input int pos);
        for (int i = pos; i + 1 < box_count; i++)
            box_list[i] = box_list[i + 1];
        box_count--;
    endfunction

    function automatic hit_rsp_t apply_command(input hit_cmd_t c);
        hit_rsp_t r;
        int hit_at;
        r = '0;
        case (c.code) inside
            CMD_INSERT:
            begin
                if (box_count >= DEPTH_DEF)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = box_count; i > 0; i--)
                        box_list[i] = box_list[i - 1];
                    box_list[0] = c.box;
                    box_count++;
                end
            end
            CMD_REMOVE_LAST:
            begin
                if (box_count == 0)
                    r.status = ST_RANGE;
                else
                    box_count--;
            end
            CMD_ERASE_INDEX:
            begin
                if (int'(c.slot) >= box_count)
                    r.status = ST_RANGE;
                else
                    drop_box(int'(c.slot));
            end
            CMD_ERASE_POINT, CMD_LOOKUP:
            begin
                if (box_count == 0)
                    r.status = ST_RANGE;
                else
                begin
                    hit_at = first_box_hit(c.px, c.py);
                    if (hit_at >= 0)
                    begin
                        r.found = 1'b1;
                        r.hit = hit_at[HIT_W-1:0];
                        if (c.code == CMD_ERASE_POINT)
                            drop_box(hit_at);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = box_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic box_t random_box();
        int kind, x0, y0, x1, y1;
        kind = $urandom_range(0, 9);
        x0 = $urandom_range(0, COORD_MAX);
        y0 = $urandom_range(0, COORD_MAX);
        x1 = $urandom_range(0, COORD_MAX);
        y1 = $urandom_range(0, COORD_MAX);
        if (kind == 0)
        begin
            x0 = $urandom_range(0, 1) * COORD_MAX;
            y0 = $urandom_range(0, 1) * COORD_MAX;
            x1 = $urandom_range(0, 1) * COORD_MAX;
            y1 = $urandom_range(0, 1) * COORD_MAX;
        end
        else if (kind == 1)
        begin
            if ($urandom_range(0, 1))
                x1 = x0;
            else
                y1 = y0;
        end
        else if (kind < 6)
        begin
            x1 = x0 + $urandom_range(0, 200);
            y1 = y0 + $urandom_range(0, 200);
            if (x1 > COORD_MAX)
                x1 = COORD_MAX;
            if (y1 > COORD_MAX)
                y1 = COORD_MAX;
            if ($urandom_range(0, 1))
                return make_box(x1, y1, x0, y0);
        end
        return make_box(x0, y0, x1, y1);
    endfunction

    function automatic hit_cmd_t random_fields(input logic [CMD_W-1:0] code);
        hit_cmd_t c;
        c.code = code;
        c.box = make_box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        c.px = PCOORD_W'($urandom_range(0, COORD_MAX));
        c.py = PCOORD_W'($urandom_range(0, COORD_MAX));
        c.slot = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
        return c;
    endfunction

    function automatic int coord_near(input int a, input int b);
        int lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if ($urandom_range(0, 4) != 0 && hi - lo >= 2)
            return $urandom_range(lo + 1, hi - 1);
        return $urandom_range(0, 1) ? lo : hi;
    endfunction

    function automatic hit_cmd_t random_command(input int phase);
        hit_cmd_t c;
        box_t b;
        int r, insert_pct;
        insert_pct = (phase == 0) ? 55 : (phase == 1) ? 15 : 30;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
        begin
            c = random_fields(CMD_INSERT);
            c.box = random_box();
            return c;
        end
        r = $urandom_range(0, 99);
        if (r < 15)
            c = random_fields(CMD_REMOVE_LAST);
        else if (r < 35)
        begin
            c = random_fields(CMD_ERASE_INDEX);
            if (box_count > 0 && $urandom_range(0, 9) < 8)
                c.slot = SLOT_W'($urandom_range(0, box_count - 1));
        end
        else if (r < 97)
        begin
            c = random_fields((r < 60) ? CMD_ERASE_POINT : CMD_LOOKUP);
            if (box_count > 0 && $urandom_range(0, 9) < 7)
            begin
                b = box_list[$urandom_range(0, box_count - 1)];
                c.px = PCOORD_W'(coord_near(int'(b.ax), int'(b.bx)));
                c.py = PCOORD_W'(coord_near(int'(b.ay), int'(b.by)));
            end
        end
        else
            c = random_fields(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)));
        return c;
    endfunction

    task automatic send_cmd(input hit_cmd_t c);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) >= 45)
            gap = idle_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command <= c.code;
        corner_ax <= c.box.ax;
        corner_ay <= c.box.ay;
        corner_bx <= c.box.bx;
        corner_by <= c.box.by;
        point_x <= c.px;
        point_y <= c.py;
        slot_index <= c.slot;
        do
            @(posedge clk);
        while (cmd_stall);
        pending_rsp = {pending_rsp, apply_command(c)};
    endtask

    task automatic send_probe(input logic [CMD_W-1:0] code, input int px, input int py,
                              input int slot);
        hit_cmd_t c;
        c = random_fields(code);
        c.px = px[PCOORD_W-1:0];
        c.py = py[PCOORD_W-1:0];
        c.slot = slot[SLOT_W-1:0];
        send_cmd(c);
    endtask

    task automatic test_empty_table();
        no_idle = 1'b1;
        send_probe(CMD_REMOVE_LAST, 0, 0, 0);
        send_probe(CMD_ERASE_INDEX, 0, 0, (1 << SLOT_W) - 1);
        send_probe(CMD_ERASE_POINT, 2048, 2048, 0);
        send_probe(CMD_LOOKUP, 2048, 2048, 0);
        send_probe(CMD_UNUSED_LAST, COORD_MAX, COORD_MAX, 0);
    endtask

    task automatic test_fill_to_full();
        hit_cmd_t c;
        box_t fixed_boxes [5];
        fixed_boxes[0] = make_box(0, 0, COORD_MAX, COORD_MAX);
        fixed_boxes[1] = make_box(COORD_MAX, COORD_MAX, 0, 0);
        fixed_boxes[2] = make_box(100, 100, 100, 300);
        fixed_boxes[3] = make_box(100, 100, 300, 100);
        fixed_boxes[4] = make_box(COORD_MAX, 0, 0, COORD_MAX);
        for (int i = 0; i <= DEPTH_DEF; i++)
        begin
            c = random_fields(CMD_INSERT);
            c.box = (i < 5) ? fixed_boxes[i] : random_box();
            send_cmd(c);
        end
    endtask

    task automatic test_edge_points();
        send_probe(CMD_LOOKUP, 0, 2048, 0);
        send_probe(CMD_LOOKUP, COORD_MAX, 2048, 0);
        send_probe(CMD_LOOKUP, 1, COORD_MAX - 1, 0);
        send_probe(CMD_ERASE_POINT, 200, 101, 0);
        send_probe(CMD_ERASE_INDEX, 0, 0, box_count - 1);
        send_probe(CMD_ERASE_INDEX, 0, 0, box_count);
        send_probe(CMD_REMOVE_LAST, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int n_items, input bit quiet);
        hit_cmd_t c;
        int sent, phase;
        no_idle = quiet;
        sent = 0;
        phase = 2;
        while (sent < n_items)
        begin
            if (sent % 120 == 0)
                phase = $urandom_range(0, 2);
            c = random_command(phase);
            send_cmd(c);
            if (c.code <= CMD_LOOKUP)
                sent++;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        command <= CMD_INSERT;
        corner_ax <= '0;
        corner_ay <= '0;
        corner_bx <= '0;
        corner_by <= '0;
        point_x <= '0;
        point_y <= '0;
        slot_index <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_empty_table();
        test_fill_to_full();
        test_edge_points();
        test_random_traffic(1700, 1'b0);
        test_random_traffic(150, 1'b1);
        cmd_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            if (no_idle)
                @(posedge clk);
            else
            begin
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 10))
                    @(posedge clk);
                if (!no_idle)
                begin
                    rsp_stall <= 1'b1;
                    repeat (idle_len()) @(posedge clk);
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected transaction at %0t: found %0d hit_index %0d",
                             $realtime, found, hit_index);
            end
            else
            begin
                rsp_want = pending_rsp.pop_front();
                if (found !== rsp_want.found || hit_index !== rsp_want.hit ||
                    entry_count !== rsp_want.count || status !== rsp_want.status)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $write("mismatch at %0t: found %0d/%0d hit_index %0d/%0d ",
                               $realtime, found, rsp_want.found, hit_index, rsp_want.hit);
                        $display("entry_count %0d/%0d status %0d/%0d (got/exp)",
                                 entry_count, rsp_want.count, status, rsp_want.status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

FILE: filelist.f
hw/rtl/rhtt_pkg.sv
hw/rtl/rhtt_datapath.sv
hw/rtl/rhtt_ctrl.sv
hw/rtl/rectangle_hit_test_table_core.sv
tb/sv/testbench.sv
